### rtl/simple_risc_instruction_execute_top_assert.svh
// Assertion macros for the execute block checker.
// Used by the checker file only; no other dependencies.
`ifndef SIMPLE_RISC_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
`define SIMPLE_RISC_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SRX_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Implication with the consequent checked in the next cycle.
`define SRX_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

### rtl/srx_pkg.sv
// Package for the execute block: opcodes, fault codes, I/O register indexes.
// No dependencies.
package srx_pkg;
	typedef enum logic [7:0] {
		OP_ADD = 8'd0, OP_SUB = 8'd1, OP_AND = 8'd2, OP_OR = 8'd3,
		OP_SLL = 8'd4, OP_SRA = 8'd5, OP_SRL = 8'd6, OP_BEQ = 8'd7,
		OP_BNE = 8'd8, OP_BLT = 8'd9, OP_BGT = 8'd10, OP_BLE = 8'd11,
		OP_BGE = 8'd12, OP_JAL = 8'd13, OP_LW = 8'd14, OP_SW = 8'd15,
		OP_RETI = 8'd16, OP_IN = 8'd17, OP_OUT = 8'd18, OP_HALT = 8'd19
	} op_t;
	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_JAL  = 2'd1;
	localparam logic [1:0] FAULT_MEM  = 2'd2;
	localparam logic [1:0] FAULT_IO   = 2'd3;
	localparam int IO_EN0 = 0, IO_EN1 = 1, IO_EN2 = 2, IO_ST0 = 3, IO_ST1 = 4,
		IO_ST2 = 5, IO_HANDLER = 6, IO_RETURN = 7, IO_CLKS = 8, IO_TEN = 11,
		IO_TCUR = 12, IO_TMAX = 13, IO_MONCMD = 22;
	localparam int JAL_LIMIT = 4096;
	typedef enum logic {ST_READ = 1'b0, ST_EXEC = 1'b1} state_t;
endpackage

### rtl/srx_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module srx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/simple_risc_instruction_execute_top.sv
// Execute stage of a 16-register, 32-bit machine.
// Depends on srx_pkg and srx_ram.
//
// Usage: one decoded instruction request enters on s_axis, and one result leaves
// on m_axis for each instruction. An instruction passes through ST_READ and then
// ST_EXEC. In ST_READ, which ends at the accepting edge, the operands are read
// from the register file, the data memory address is formed and its synchronous
// read is issued. In ST_EXEC the load data returns and the remaining state is
// updated. The result is registered in the output register at the end of
// ST_EXEC, which raises m_axis_tvalid. No request is taken in ST_EXEC, because
// each instruction must commit its register and memory writes before the next
// one reads its operands. s_axis_tready is low in the execute cycle, during the
// clearing sweep, and while a result waits in the output register and the
// receiver stalls.
// Reset clears the registers, the I/O registers and the handler flag at once.
// The data memory is cleared after reset by a sweep that zeroes its DATA_WORDS
// words in turn, during which no request is accepted.
module simple_risc_instruction_execute_top
	import srx_pkg::*;
#(
	parameter int DATA_WORDS   = 4096,
	parameter int IO_REG_COUNT = 23
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: action[7:0], dest_reg[11:8], src_reg_a[15:12], src_reg_b[19:16],
	// imm_first[31:20], imm_second[43:32], pc[55:44], zero[63:56]
	input  logic [63:0] s_axis_tdata,
	// tuser: irq2_pulse
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: next_pc[11:0], halted[12], fault[14:13], irq_entered[15]
	output logic [15:0] m_axis_tdata
);
	localparam int AW = $clog2(DATA_WORDS);

	logic [31:0] rf_q [16];
	logic [31:0] io_q [IO_REG_COUNT];
	logic        in_handler_q;
	state_t      state_q, state_d;
	logic [63:0] ins_s1;
	logic        irq_s1;
	logic [31:0] a_s1, b_s1, d_s1;
	logic [32:0] sum_s1;
	logic        clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic        out_valid_q;
	logic [15:0] out_data_q;

	logic        accept;
	logic [7:0]  op;
	logic [3:0]  rd;
	logic [31:0] i1, i2, a_c, b_c, d_c;
	logic [32:0] sum_c;
	logic        mem_ok;
	logic [31:0] mem_rdata;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0] mem_wdata;

	assign s_axis_tready = (state_q == ST_READ) && !clr_q &&
		(!out_valid_q || m_axis_tready);
	assign accept = s_axis_tvalid && s_axis_tready;

	// Operand read with immediates forwarded into R1 and R2.
	always_comb begin
		logic [3:0] r_d, r_s, r_t;
		logic w1, w2;
		r_d = s_axis_tdata[11:8];
		r_s = s_axis_tdata[15:12];
		r_t = s_axis_tdata[19:16];
		w1 = (r_d == 4'd1) || (r_s == 4'd1) || (r_t == 4'd1);
		w2 = (r_d == 4'd2) || (r_s == 4'd2) || (r_t == 4'd2);
		i1 = w1 ? {{20{s_axis_tdata[31]}}, s_axis_tdata[31:20]} : rf_q[1];
		i2 = w2 ? {{20{s_axis_tdata[43]}}, s_axis_tdata[43:32]} : rf_q[2];
		a_c = (r_s == 4'd0) ? 32'd0 : (r_s == 4'd1) ? i1 : (r_s == 4'd2) ? i2 : rf_q[r_s];
		b_c = (r_t == 4'd0) ? 32'd0 : (r_t == 4'd1) ? i1 : (r_t == 4'd2) ? i2 : rf_q[r_t];
		d_c = (r_d == 4'd0) ? 32'd0 : (r_d == 4'd1) ? i1 : (r_d == 4'd2) ? i2 : rf_q[r_d];
		sum_c = {a_c[31], a_c} + {b_c[31], b_c};
	end

	// The data memory; during the clearing sweep it is written with zero.
	srx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (sum_c[AW-1:0]),
		.rdata (mem_rdata)
	);

	// Next state.
	always_comb begin
		case (state_q)
			ST_READ: state_d = accept ? ST_EXEC : ST_READ;
			ST_EXEC: state_d = ST_READ;
			default: state_d = ST_READ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READ;
		end else begin
			state_q <= state_d;
		end
	end

	// First-stage capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1 <= s_axis_tdata;
			irq_s1 <= s_axis_tuser;
			a_s1   <= a_c;
			b_s1   <= b_c;
			d_s1   <= d_c;
			sum_s1 <= sum_c;
		end
	end

	assign op = ins_s1[7:0];
	assign rd = ins_s1[11:8];
	assign mem_ok = !sum_s1[32] && (sum_s1 < 33'(DATA_WORDS));

	assign mem_we = clr_q || ((state_q == ST_EXEC) && (op == OP_SW) && mem_ok);
	assign mem_waddr = clr_q ? clr_cnt_q : sum_s1[AW-1:0];
	assign mem_wdata = clr_q ? 32'd0 : d_s1;

	// Execute and commit architectural state in ST_EXEC; immediates reach R1/R2 on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [11:0] pcv, nxt;
		logic [1:0]  flt;
		logic        hlt, ent, io_ok, wr, fire, hnd;
		logic [31:0] res;
		logic [31:0] io_n [IO_REG_COUNT];
		logic signed [31:0] sa, sb;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= 32'd0;
			for (int i = 0; i < IO_REG_COUNT; i++) io_q[i] <= 32'd0;
			in_handler_q <= 1'b0;
			out_valid_q  <= 1'b0;
			clr_q        <= 1'b1;
			clr_cnt_q    <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(DATA_WORDS - 1)) clr_q <= 1'b0;
			end
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (accept) begin
				// Immediates land in R1/R2 now; forwarding covered the read.
				if ((s_axis_tdata[11:8] == 4'd1) || (s_axis_tdata[15:12] == 4'd1) ||
					(s_axis_tdata[19:16] == 4'd1)) rf_q[1] <= i1;
				if ((s_axis_tdata[11:8] == 4'd2) || (s_axis_tdata[15:12] == 4'd2) ||
					(s_axis_tdata[19:16] == 4'd2)) rf_q[2] <= i2;
			end
			if (state_q == ST_EXEC) begin
				pcv = ins_s1[55:44];
				nxt = pcv + 12'd1;
				flt = FAULT_NONE;
				hlt = 1'b0;
				ent = 1'b0;
				wr  = 1'b0;
				res = 32'd0;
				hnd = in_handler_q;
				sa = a_s1;
				sb = b_s1;
				for (int i = 0; i < IO_REG_COUNT; i++) io_n[i] = io_q[i];
				io_ok = !sum_s1[32] && (sum_s1 < 33'(IO_REG_COUNT));
				case (op)
					OP_ADD: begin wr = 1'b1; res = a_s1 + b_s1; end
					OP_SUB: begin wr = 1'b1; res = a_s1 - b_s1; end
					OP_AND: begin wr = 1'b1; res = a_s1 & b_s1; end
					OP_OR:  begin wr = 1'b1; res = a_s1 | b_s1; end
					OP_SLL: begin wr = 1'b1; res = a_s1 << b_s1[4:0]; end
					OP_SRA: begin wr = 1'b1; res = 32'(sa >>> b_s1[4:0]); end
					OP_SRL: begin wr = 1'b1; res = a_s1 >> b_s1[4:0]; end
					OP_BEQ: if (sa == sb) nxt = d_s1[11:0];
					OP_BNE: if (sa != sb) nxt = d_s1[11:0];
					OP_BLT: if (sa < sb) nxt = d_s1[11:0];
					OP_BGT: if (sa > sb) nxt = d_s1[11:0];
					OP_BLE: if (sa <= sb) nxt = d_s1[11:0];
					OP_BGE: if (sa >= sb) nxt = d_s1[11:0];
					OP_JAL: begin
						if (d_s1 < 32'(JAL_LIMIT)) begin
							rf_q[15] <= {20'd0, nxt};
							nxt = d_s1[11:0];
						end else flt = FAULT_JAL;
					end
					OP_LW: begin
						if (mem_ok) begin wr = 1'b1; res = mem_rdata; end
						else flt = FAULT_MEM;
					end
					OP_SW: if (!mem_ok) flt = FAULT_MEM;
					OP_RETI: begin
						nxt = io_q[IO_RETURN][11:0];
						hnd = 1'b0;
					end
					OP_IN: begin
						if (io_ok) begin
							wr = 1'b1;
							res = io_q[sum_s1[4:0]];
							if (sum_s1[4:0] == 5'(IO_MONCMD)) io_n[IO_MONCMD] = 32'd0;
						end else flt = FAULT_IO;
					end
					OP_OUT: begin
						if (io_ok) begin
							io_n[sum_s1[4:0]] = d_s1;
							if (io_n[IO_MONCMD] == 32'd1) io_n[IO_MONCMD] = 32'd0;
						end else flt = FAULT_IO;
					end
					default: begin hlt = 1'b1; nxt = pcv; end
				endcase
				if (wr && rd != 4'd0) rf_q[rd] <= res;
				// Timer.
				if (io_n[IO_TEN] == 32'd1 && io_n[IO_TCUR] < io_n[IO_TMAX]) begin
					if (io_n[IO_TCUR] + 32'd1 == io_n[IO_TMAX]) begin
						io_n[IO_ST0] = 32'd1;
						io_n[IO_TCUR] = 32'd0;
					end else io_n[IO_TCUR] = io_n[IO_TCUR] + 32'd1;
				end
				if (irq_s1) io_n[IO_ST2] = 32'd1;
				// Interrupt entry; a return in this instruction has already left the handler.
				fire = ((io_n[IO_EN0][0] & io_n[IO_ST0][0]) |
					(io_n[IO_EN1][0] & io_n[IO_ST1][0]) |
					(io_n[IO_EN2][0] & io_n[IO_ST2][0]));
				if (fire) begin
					if (!hnd && !hlt) begin
						io_n[IO_RETURN] = {20'd0, nxt};
						nxt = io_n[IO_HANDLER][11:0];
						hnd = 1'b1;
						ent = 1'b1;
					end
					io_n[IO_ST2] = 32'd0;
				end
				in_handler_q <= hnd;
				// IO_CLKS advances once per executed instruction and wraps to zero instead of reaching all ones.
				if (io_n[IO_CLKS] + 32'd1 == 32'hFFFF_FFFF) io_n[IO_CLKS] = 32'd0;
				else io_n[IO_CLKS] = io_n[IO_CLKS] + 32'd1;
				for (int i = 0; i < IO_REG_COUNT; i++) io_q[i] <= io_n[i];
				out_valid_q <= 1'b1;
				out_data_q  <= {ent, flt, hlt, nxt};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
endmodule

### rtl/srx_checker.sv
// Port-level checker for the execute block, bound to the top level.
// Depends on simple_risc_instruction_execute_top_assert.svh.
`include "simple_risc_instruction_execute_top_assert.svh"
module srx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	// A stalled result holds.
	`SRX_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// Requests are never accepted back to back.
	`SRX_ASSERT_NEXT(a_gap, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// Every accepted request is followed by a valid result on m_axis.
	`SRX_ASSERT_NEXT(a_res, s_axis_tvalid && s_axis_tready, ##1 m_axis_tvalid)
	// A halt result never reports an interrupt entry.
	`SRX_ASSERT_IMP(a_halt, m_axis_tvalid && m_axis_tdata[12], !m_axis_tdata[15])
endmodule

bind simple_risc_instruction_execute_top srx_checker u_srx_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
